// ===== hdl/lpr_pkg.sv =====
// ============================================================================
// lpr_pkg: shared types and constants for the LRU page replacement block
// Controller command bundle and fault counter constants.
// ============================================================================
`default_nettype none

package lpr_pkg;

	localparam int unsigned COUNT_BITS = 32;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;    // capture the incoming request
		logic commit;  // look up, update frames, load the result register
	} dp_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/lpr_if.sv =====
// ============================================================================
// lpr_if: request and result channels of the LRU page replacement block
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ============================================================================
`default_nettype none

interface lpr_req_if #(
	parameter int PAGE_BITS = 16
);
	logic                 valid;
	logic                 ready;
	logic [PAGE_BITS-1:0] page_number;
	logic                 last_access;

	modport source (output valid, output page_number, output last_access, input ready);
	modport sink   (input valid, input page_number, input last_access, output ready);
endinterface

interface lpr_rsp_if #(
	parameter int PAGE_BITS  = 16,
	parameter int FRAME_BITS = 2
);
	logic                  valid;
	logic                  ready;
	logic                  hit;
	logic [FRAME_BITS-1:0] frame_index;
	logic                  evicted_valid;
	logic [PAGE_BITS-1:0]  evicted_page;
	logic [31:0]           fault_total;
	logic                  last_echo;

	modport source (output valid, output hit, output frame_index, output evicted_valid,
		output evicted_page, output fault_total, output last_echo, input ready);
	modport sink   (input valid, input hit, input frame_index, input evicted_valid,
		input evicted_page, input fault_total, input last_echo, output ready);
endinterface

`default_nettype wire

// ===== hdl/lpr_ctrl.sv =====
// ============================================================================
// lpr_ctrl: request sequencing for the LRU page replacement block
// Two-state controller; owns the result valid flag.
// ============================================================================
`default_nettype none

module lpr_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output lpr_pkg::dp_cmd_t    cmd
);

	typedef enum logic {
		S_IDLE,
		S_UPDATE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   room;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign room      = !out_valid_q || rsp_ready;

	always_comb begin
		cmd.load   = req_valid && (state_q == S_IDLE);
		cmd.commit = (state_q == S_UPDATE) && room;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.load) state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (cmd.commit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	// a committed result is presented on the next cycle
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("result not presented after commit");

	// an accepted request is always followed by the update step
	a_load_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_UPDATE))
		else $error("accepted request did not enter update");
`endif

endmodule

`default_nettype wire

// ===== hdl/lpr_dp.sv =====
// ============================================================================
// lpr_dp: frame table, LRU ranks, fault counter and result register
// Parallel tag compare, frame choice and rank update in the commit cycle.
// ============================================================================
`default_nettype none

module lpr_dp #(
	parameter int NUM_FRAMES = 4,
	parameter int PAGE_BITS  = 16,
	parameter int FRAME_BITS = 2
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire lpr_pkg::dp_cmd_t                cmd,
	input  wire logic [PAGE_BITS-1:0]            page_number,
	input  wire logic                            last_access,
	output logic                                 hit,
	output logic [FRAME_BITS-1:0]                frame_index,
	output logic                                 evicted_valid,
	output logic [PAGE_BITS-1:0]                 evicted_page,
	output logic [lpr_pkg::COUNT_BITS-1:0]       fault_total,
	output logic                                 last_echo
);

	localparam logic [FRAME_BITS-1:0] RANK_MAX = FRAME_BITS'(NUM_FRAMES - 1);

	logic [PAGE_BITS-1:0]           page_s1;
	logic                           last_s1;
	logic [PAGE_BITS-1:0]           pages_q [NUM_FRAMES];
	logic [NUM_FRAMES-1:0]          valid_q;
	logic [FRAME_BITS-1:0]          rank_q  [NUM_FRAMES];
	logic [lpr_pkg::COUNT_BITS-1:0] fault_q;

	logic                           hit_w;
	logic                           empty_found;
	logic [FRAME_BITS-1:0]          match_idx;
	logic [FRAME_BITS-1:0]          empty_idx;
	logic [FRAME_BITS-1:0]          victim_idx;
	logic [FRAME_BITS-1:0]          sel_idx;
	logic [FRAME_BITS-1:0]          sel_rank;
	logic                           ev_valid_w;
	logic [lpr_pkg::COUNT_BITS-1:0] fault_next;

	// Priority encoders: lowest index wins. When every frame is valid the ranks
	// form a permutation, so the least recent frame is the one at the top rank.
	always_comb begin
		hit_w       = 1'b0;
		empty_found = 1'b0;
		match_idx   = '0;
		empty_idx   = '0;
		victim_idx  = '0;
		for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
			if (valid_q[i] && (pages_q[i] == page_s1)) begin
				hit_w     = 1'b1;
				match_idx = FRAME_BITS'(i);
			end
			if (!valid_q[i]) begin
				empty_found = 1'b1;
				empty_idx   = FRAME_BITS'(i);
			end
			if (rank_q[i] == RANK_MAX) victim_idx = FRAME_BITS'(i);
		end
		if (hit_w) sel_idx = match_idx;
		else if (empty_found) sel_idx = empty_idx;
		else sel_idx = victim_idx;
		sel_rank   = rank_q[sel_idx];
		ev_valid_w = !hit_w && !empty_found;
		if (hit_w || (fault_q == lpr_pkg::COUNT_MAX)) fault_next = fault_q;
		else fault_next = fault_q + lpr_pkg::COUNT_BITS'(1);
	end

	// Control state: valid bits, ranks, fault counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fault_q <= '0;
			for (int i = 0; i < NUM_FRAMES; i++) rank_q[i] <= '0;
		end else if (cmd.commit) begin
			if (last_s1) begin
				valid_q <= '0;
				fault_q <= '0;
				for (int i = 0; i < NUM_FRAMES; i++) rank_q[i] <= '0;
			end else begin
				fault_q <= fault_next;
				for (int i = 0; i < NUM_FRAMES; i++) begin
					if (FRAME_BITS'(i) == sel_idx) begin
						valid_q[i] <= 1'b1;
						rank_q[i]  <= '0;
					end else if (valid_q[i] && (!hit_w || (rank_q[i] < sel_rank))) begin
						rank_q[i] <= rank_q[i] + FRAME_BITS'(1);
					end
				end
			end
		end
	end

	// Payload: request capture, page tags, result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_s1 <= page_number;
			last_s1 <= last_access;
		end
		if (cmd.commit) begin
			if (!hit_w) pages_q[sel_idx] <= page_s1;
			hit           <= hit_w;
			frame_index   <= sel_idx;
			evicted_valid <= ev_valid_w;
			evicted_page  <= ev_valid_w ? pages_q[victim_idx] : '0;
			fault_total   <= fault_next;
			last_echo     <= last_s1;
		end
	end

`ifndef SYNTH
	// end of string wipes the frame set and the count
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && last_s1) |=> (valid_q == '0) && (fault_q == '0))
		else $error("state not cleared after last reference");

	// a fault never wraps the counter back to zero
	a_fault_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !hit_w && !last_s1) |=> (fault_q != '0))
		else $error("fault counter wrapped");
`endif

endmodule

`default_nettype wire

// ===== hdl/lru_page_replacement.sv =====
// ============================================================================
// lru_page_replacement: LRU page replacement over a fully associative frame set
// Tracks resident pages, recency ranks and a saturating fault count.
// ============================================================================
// Usage:
//  - req (sink): one page reference per request, page_number plus last_access.
//  - rsp (source): one result per request: hit, frame_index, evicted_valid,
//    evicted_page (zero unless a page was evicted), fault_total, last_echo.
//  - One request at a time: the next request is taken only after the update
//    step of the last one. The request is first captured; then the parallel
//    tag compare, frame choice and rank update run against the frame table
//    and write the result register. rsp.valid rises on the edge that ends
//    the update cycle.
//  - A waiting result does not block the next request: req.ready is high
//    again right after the update cycle. If rsp stalls and a second request
//    reaches its update cycle, it holds there until the result register frees.
//  - Reset (arst_n low) clears all valid bits, ranks, the fault count and the
//    result valid flag; no clearing pass is needed.
//  - A request with last_access set clears frames and count after its result.
// ============================================================================
`default_nettype none

module lru_page_replacement #(
	parameter int NUM_FRAMES = 4,
	parameter int PAGE_BITS  = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	lpr_req_if.sink     req,
	lpr_rsp_if.source   rsp
);

	localparam int FRAME_BITS = $clog2(NUM_FRAMES);

	lpr_pkg::dp_cmd_t cmd;

	// sequencing and result handshake
	lpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// frame table, LRU ranks, fault counter and result payload
	lpr_dp #(
		.NUM_FRAMES (NUM_FRAMES),
		.PAGE_BITS  (PAGE_BITS),
		.FRAME_BITS (FRAME_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.page_number   (req.page_number),
		.last_access   (req.last_access),
		.hit           (rsp.hit),
		.frame_index   (rsp.frame_index),
		.evicted_valid (rsp.evicted_valid),
		.evicted_page  (rsp.evicted_page),
		.fault_total   (rsp.fault_total),
		.last_echo     (rsp.last_echo)
	);

endmodule

`default_nettype wire
